// ===== rtl/core/utf8d_pkg.sv =====
package utf8d_pkg;

  // Width of the reported character count, fixed by the result beat.
  localparam int unsigned CharCountWidth = 32;
  localparam int unsigned CodePointWidth = 21;

  // Payload masks for each byte class.
  localparam logic [7:0] AsciiMask = 8'h7F;
  localparam logic [7:0] Lead2Mask = 8'h1F;
  localparam logic [7:0] Lead3Mask = 8'h0F;
  localparam logic [7:0] Lead4Mask = 8'h07;
  localparam logic [7:0] ContMask  = 8'h3F;

  localparam logic [7:0] NulByte     = 8'h00;
  localparam logic [7:0] InvalidBase = 8'hF8;
  localparam logic [7:0] Lead3Base   = 8'hE0;
  localparam logic [7:0] Lead4Base   = 8'hF0;
  localparam logic [1:0] ContTag     = 2'b10;

  typedef enum logic [1:0] {
    VERDICT_BUSY = 2'd0,
    VERDICT_GOOD = 2'd1,
    VERDICT_BAD  = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [CodePointWidth-1:0] code_point;
    logic                      point_ready;
    logic [CharCountWidth-1:0] char_count;
    verdict_e                  verdict;
  } out_beat_t;

  // Decoder state other than the character counter.
  typedef struct packed {
    logic [1:0]                owed_bytes;
    logic [CodePointWidth-1:0] partial_point;
    logic                      stopped;
    verdict_e                  held_verdict;
  } dec_state_t;

  localparam dec_state_t DecStateReset = '{
    owed_bytes:    2'd0,
    partial_point: '0,
    stopped:       1'b0,
    held_verdict:  VERDICT_BUSY
  };

endpackage

// ===== rtl/core/utf8d_step.sv =====
module utf8d_step #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  utf8d_pkg::in_beat_t   beat_i,
  input  utf8d_pkg::dec_state_t state_i,
  input  logic [COUNT_WIDTH-1:0] count_i,
  output utf8d_pkg::dec_state_t state_o,
  output logic [COUNT_WIDTH-1:0] count_o,
  output utf8d_pkg::out_beat_t  result_o
);
  import utf8d_pkg::*;

  logic [7:0]               b;
  logic                     is_cont;
  dec_state_t               st;
  logic [COUNT_WIDTH-1:0]   cnt;
  logic [CodePointWidth-1:0] cp;
  logic                     rdy;
  logic [1:0]               owed_dec;
  logic [CharCountWidth-1:0] cnt_rep;

  assign b        = beat_i.data_byte;
  assign is_cont  = (b[7:6] == ContTag);
  assign owed_dec = state_i.owed_bytes - 2'd1;

  always_comb begin
    st  = state_i;
    cnt = count_i;
    cp  = '0;
    rdy = 1'b0;
    if (!state_i.stopped) begin
      if (b == NulByte) begin
        st.held_verdict = (state_i.owed_bytes == 2'd0) ? VERDICT_GOOD : VERDICT_BAD;
        st.stopped      = 1'b1;
      end else if (b >= InvalidBase) begin
        st.held_verdict = VERDICT_BAD;
        st.stopped      = 1'b1;
      end else if (is_cont) begin
        if (state_i.owed_bytes == 2'd0) begin
          st.held_verdict = VERDICT_BAD;
          st.stopped      = 1'b1;
        end else begin
          st.partial_point = {state_i.partial_point[CodePointWidth-7:0], b[5:0] & ContMask[5:0]};
          st.owed_bytes    = owed_dec;
          if (owed_dec == 2'd0) begin
            cp               = st.partial_point;
            rdy              = 1'b1;
            st.partial_point = '0;
          end
        end
      end else if (state_i.owed_bytes != 2'd0) begin
        st.held_verdict = VERDICT_BAD;
        st.stopped      = 1'b1;
      end else begin
        if (count_i != {COUNT_WIDTH{1'b1}}) begin
          cnt = count_i + COUNT_WIDTH'(1);
        end
        if (!b[7]) begin
          cp  = CodePointWidth'(b & AsciiMask);
          rdy = 1'b1;
        end else if (b < Lead3Base) begin
          st.partial_point = CodePointWidth'(b & Lead2Mask);
          st.owed_bytes    = 2'd1;
        end else if (b < Lead4Base) begin
          st.partial_point = CodePointWidth'(b & Lead3Mask);
          st.owed_bytes    = 2'd2;
        end else begin
          st.partial_point = CodePointWidth'(b & Lead4Mask);
          st.owed_bytes    = 2'd3;
        end
      end
    end
  end

  // Count as reported, clamped to the result field.
  generate
    if (COUNT_WIDTH > CharCountWidth) begin : g_clamp
      assign cnt_rep = (|cnt[COUNT_WIDTH-1:CharCountWidth]) ? {CharCountWidth{1'b1}}
                                                            : cnt[CharCountWidth-1:0];
    end else begin : g_extend
      assign cnt_rep = CharCountWidth'(cnt);
    end
  endgenerate

  always_comb begin
    result_o.code_point  = cp;
    result_o.point_ready = rdy;
    result_o.char_count  = cnt_rep;
    result_o.verdict     = VERDICT_BUSY;
    state_o              = st;
    count_o              = cnt;
    if (beat_i.end_of_string) begin
      if (st.stopped) begin
        result_o.verdict = st.held_verdict;
      end else begin
        result_o.verdict = (st.owed_bytes == 2'd0) ? VERDICT_GOOD : VERDICT_BAD;
      end
      state_o = DecStateReset;
      count_o = '0;
    end
  end

endmodule

// ===== rtl/core/utf8_stream_decoder.sv =====
// UTF-8 stream decoder and validator.
// Input channel: in_valid_i / in_ready_o carry one string byte per beat plus
// an end_of_string flag on the last byte of the buffer.
// Output channel: out_valid_o / out_ready_i carry exactly one result beat per
// input beat: the code point when a character completes (point_ready), the
// count of characters started so far, and the verdict, which is nonzero only
// on the end_of_string beat (1 valid, 2 invalid).
// A byte accepted is held in the input register, then decoded and written
// to the result register once that register is free, and is shown on the
// output port from then on. One byte per clock while out_ready_i keeps up;
// the decode logic is one shallow pass between the two registers.
// A stalled receiver holds the result register; one more byte can wait in
// the input register, after which in_ready_o drops until the result leaves.
// Reset empties both registers and clears the decoder state and counter;
// the end_of_string beat clears them the same way after giving its verdict.
module utf8_stream_decoder #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  utf8d_pkg::in_beat_t  in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output utf8d_pkg::out_beat_t out_beat_o
);
  import utf8d_pkg::*;

  // Input register.
  logic     in_valid_q;
  in_beat_t in_beat_q;
  // Result register.
  logic      out_valid_q;
  out_beat_t out_beat_q;
  // Decoder state.
  dec_state_t             state_q, state_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  out_beat_t              result_d;

  logic out_free;   // result register can take a new beat
  logic advance;    // input register beat moves into the result register

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  utf8d_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .beat_i  (in_beat_q),
    .state_i (state_q),
    .count_i (count_q),
    .state_o (state_d),
    .count_o (count_d),
    .result_o(result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= DecStateReset;
      count_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
        count_q <= count_d;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_beat_q <= in_beat_i;
    end
    if (advance) begin
      out_beat_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // A shown result never carries a code point without point_ready.
  a_idle_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_beat_q.point_ready) |-> (out_beat_q.code_point == '0))
    else $error("code point nonzero without point_ready");

  // No partial code point is kept while nothing is owed.
  a_partial_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.owed_bytes == 2'd0) |-> (state_q.partial_point == '0))
    else $error("partial code point left over");

  // The end marker returns the decoder to its reset state.
  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_beat_q.end_of_string) |=>
      (state_q == DecStateReset && count_q == '0))
    else $error("state not cleared after end of string");

  // An empty input register always takes a beat.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input stalled while empty");

endmodule
